FILE: src/daylight_illuminant_spectrum_assert.svh
// Assertion macros shared by the daylight spectrum RTL.
`ifndef DAYLIGHT_ILLUMINANT_SPECTRUM_ASSERT_SVH
`define DAYLIGHT_ILLUMINANT_SPECTRUM_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dis_pkg.sv
// Shared types, constants and basis tables of the daylight spectrum block.
`default_nettype none

package dis_pkg;

  localparam int WlWidth           = 10;
  localparam int PowWidth          = 23;
  localparam int TempWidth         = 15;
  localparam int TabLen            = 107;
  localparam int IdxWidth          = 7;
  localparam int FracWidth         = 3;
  localparam int WeightWidth       = 24;
  localparam int SampleWidth       = 18;
  localparam int QueueDepthDefault = 4;

  localparam logic [TempWidth-1:0] TempReset = 15'd6504;

  typedef logic signed [14:0] tab_entry_t;

  // basis tables in hundredths, 300..830 nm at 5 nm
  localparam tab_entry_t S0Tab [TabLen] = '{
    4,302,600,1780,2960,4245,5530,5630,5730,5955,6180,6165,6150,
    6515,6880,6610,6340,6460,6580,8030,9480,9980,10480,10535,10590,10135,
    9680,10535,11390,11975,12560,12555,12550,12340,12130,12130,12130,11740,11350,
    11330,11310,11195,11080,10865,10650,10765,10880,10705,10530,10485,10440,10220,
    10000,9800,9600,9555,9510,9210,8910,8980,9050,9040,9030,8935,8840,
    8620,8400,8455,8510,8350,8190,8225,8260,8375,8490,8310,8130,7660,
    7190,7310,7430,7535,7640,6985,6330,6750,7170,7435,7700,7110,6520,
    5645,4770,5815,6860,6680,6500,6550,6600,6350,6100,5715,5330,5610,
    5890,6040,6190
  };
  localparam tab_entry_t S1Tab [TabLen] = '{
    2,226,450,1345,2240,3220,4200,4130,4060,4110,4160,3980,3800,
    4020,4240,4045,3850,3675,3500,3920,4340,4485,4630,4510,4390,4050,
    3710,3690,3670,3630,3590,3425,3260,3025,2790,2610,2430,2220,2010,
    1815,1620,1470,1320,1090,860,735,610,515,420,305,190,95,
    0,-80,-160,-255,-350,-350,-350,-465,-580,-650,-720,-790,-860,
    -905,-950,-1020,-1090,-1080,-1070,-1135,-1200,-1300,-1400,-1380,-1360,-1280,
    -1200,-1265,-1330,-1310,-1290,-1175,-1060,-1110,-1160,-1190,-1220,-1120,-1020,
    -900,-780,-950,-1120,-1080,-1040,-1050,-1060,-1015,-970,-900,-830,-880,
    -930,-955,-980
  };
  localparam tab_entry_t S2Tab [TabLen] = '{
    0,100,200,300,400,625,850,815,780,725,670,600,530,
    570,610,455,300,210,120,5,-110,-80,-50,-60,-70,-95,
    -120,-190,-260,-275,-290,-285,-280,-270,-260,-260,-260,-220,-180,
    -165,-150,-140,-130,-125,-120,-110,-100,-75,-50,-40,-30,-15,
    0,10,20,35,50,130,210,265,320,365,410,440,470,
    490,510,590,670,700,730,795,860,920,980,1000,1020,925,
    830,895,960,905,850,775,700,730,760,780,800,735,670,
    595,520,630,740,710,680,690,700,670,640,595,550,580,
    610,630,650
  };

  typedef struct packed {
    logic [WlWidth-1:0]   wl;
    logic [IdxWidth-1:0]  idx;
    logic [FracWidth-1:0] frac;
  } item_t;

  typedef struct packed {
    logic signed [WeightWidth-1:0] w1;
    logic signed [WeightWidth-1:0] w2;
  } weights_t;

endpackage

`default_nettype wire

FILE: src/dis_weights.sv
// Weight engine: derives m1/m2 (Q4.20) from the temperature with a shared serial mul/div unit.
`default_nettype none

module dis_weights (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dis_pkg::TempWidth-1:0]     cfg_wdata_i,
  output logic                              busy_o,
  output dis_pkg::weights_t                 weights_o
);
  import dis_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StIssue = 4'b0010,
    StIter  = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  typedef enum logic [2:0] {DstNone, DstX, DstY, DstM, DstN1, DstN2} dst_e;

  localparam logic [4:0] StepT   = 5'd0;
  localparam logic [4:0] StepT3  = 5'd1;
  localparam logic [4:0] StepX1  = 5'd2;
  localparam logic [4:0] StepX2  = 5'd3;
  localparam logic [4:0] StepX3  = 5'd4;
  localparam logic [4:0] StepY1  = 5'd5;
  localparam logic [4:0] StepY2  = 5'd6;
  localparam logic [4:0] StepY3  = 5'd7;
  localparam logic [4:0] StepY4  = 5'd8;
  localparam logic [4:0] StepM1  = 5'd9;
  localparam logic [4:0] StepM2  = 5'd10;
  localparam logic [4:0] StepN1a = 5'd11;
  localparam logic [4:0] StepN1b = 5'd12;
  localparam logic [4:0] StepN2a = 5'd13;
  localparam logic [4:0] StepN2b = 5'd14;
  localparam logic [4:0] StepW1  = 5'd15;
  localparam logic [4:0] StepW2  = 5'd16;

  localparam logic [TempWidth-1:0] TempLo    = 15'd4000;
  localparam logic [TempWidth-1:0] TempHi    = 15'd25000;
  localparam logic [TempWidth-1:0] TempSplit = 15'd7000;
  localparam logic signed [63:0]   WMax      = 64'sd8388607;
  localparam logic signed [63:0]   WMin      = -64'sd8388608;

  state_e                state_q;
  logic [4:0]            step_q;
  logic [TempWidth-1:0]  temp_q;
  logic [14:0]           t_q;
  logic [29:0]           t2_q;
  logic [44:0]           t3_q;
  logic signed [39:0]    x_q, y_q, m_q, n1_q, n2_q;
  logic signed [63:0]    acc_q;
  logic [63:0]           ra_q, rb_q, rr_q;
  logic [5:0]            cnt_q;
  logic signed [WeightWidth-1:0] w1_q, w2_q;

  logic [14:0]           tc;
  logic                  lo;
  logic                  op_mul, init, sub;
  dst_e                  dst;
  logic signed [63:0]    opa, opb, init_k;
  logic [63:0]           abs_a, abs_b, mag, rem_sh;
  logic                  neg;
  logic signed [63:0]    res, term, acc_new;
  logic signed [WeightWidth-1:0] wsat;

  function automatic logic signed [63:0] sx(input logic signed [39:0] v);
    return {{24{v[39]}}, v};
  endfunction

  // floor(v / 64)
  function automatic logic signed [63:0] sh6(input logic signed [39:0] v);
    return {{30{v[39]}}, v[39:6]};
  endfunction

  always_comb begin
    if (temp_q < TempLo) begin
      tc = TempLo;
    end else if (temp_q > TempHi) begin
      tc = TempHi;
    end else begin
      tc = temp_q;
    end
  end

  assign lo = (t_q <= TempSplit);

  // step decode: operands, accumulate mode and destination
  always_comb begin
    op_mul = 1'b0;
    init   = 1'b0;
    sub    = 1'b0;
    dst    = DstNone;
    opa    = '0;
    opb    = '0;
    init_k = '0;
    case (step_q)
      StepX1: begin
        opa    = lo ? 64'sd106418552177 : 64'sd265729626604;
        opb    = {49'd0, t_q};
        init   = 1'b1;
        init_k = lo ? 64'sd262060651 : 64'sd254519762;
      end
      StepX2: begin
        opa = lo ? 64'sd3186650985267200 : 64'sd2042042200883200;
        opb = {34'd0, t2_q};
      end
      StepX3: begin
        opa = lo ? 64'sd4946728583168000000 : 64'sd2154355595673600000;
        opb = {19'd0, t3_q};
        sub = 1'b1;
        dst = DstX;
      end
      StepY1: begin
        op_mul = 1'b1;
        opa    = 64'sd3081639035;
        opb    = sh6(x_q);
        init   = 1'b1;
        init_k = -64'sd295279002;
      end
      StepY2, StepY3: begin
        op_mul = 1'b1;
        opa    = sx(x_q);
        opb    = sh6(x_q);
        sub    = 1'b1;
      end
      StepY4: begin
        op_mul = 1'b1;
        opa    = sx(x_q);
        opb    = sh6(x_q);
        sub    = 1'b1;
        dst    = DstY;
      end
      StepM1: begin
        op_mul = 1'b1;
        opa    = 64'sd275092655;
        opb    = sh6(x_q);
        init   = 1'b1;
        init_k = 64'sd25877178;
      end
      StepM2: begin
        op_mul = 1'b1;
        opa    = 64'sd788233873;
        opb    = sh6(y_q);
        sub    = 1'b1;
        dst    = DstM;
      end
      StepN1a: begin
        op_mul = 1'b1;
        opa    = 64'sd1900845151;
        opb    = sh6(x_q);
        init   = 1'b1;
        init_k = -64'sd1451162075;
        sub    = 1'b1;
      end
      StepN1b: begin
        op_mul = 1'b1;
        opa    = 64'sd6347317418;
        opb    = sh6(y_q);
        dst    = DstN1;
      end
      StepN2a: begin
        op_mul = 1'b1;
        opa    = 64'sd33761019927;
        opb    = sh6(x_q);
        init   = 1'b1;
        init_k = 64'sd32212255;
        sub    = 1'b1;
      end
      StepN2b: begin
        op_mul = 1'b1;
        opa    = 64'sd32289242009;
        opb    = sh6(y_q);
        dst    = DstN2;
      end
      StepW1: begin
        opa = sx(n1_q) <<< 20;
        opb = sx(m_q);
      end
      StepW2: begin
        opa = sx(n2_q) <<< 20;
        opb = sx(m_q);
      end
      default: begin
        op_mul = 1'b0;
      end
    endcase
  end

  assign abs_a  = opa[63] ? 64'(-opa) : 64'(opa);
  assign abs_b  = opb[63] ? 64'(-opb) : 64'(opb);
  assign neg    = opa[63] ^ opb[63];
  assign rem_sh = {rr_q[62:0], ra_q[63]};

  always_comb begin
    mag     = op_mul ? rr_q : ra_q;
    res     = neg ? -$signed(mag) : $signed(mag);
    term    = op_mul ? (res >>> 24) : res;
    acc_new = (init ? init_k : acc_q) + (sub ? -term : term);
    if (m_q == '0) begin
      wsat = '0;
    end else if (res > WMax) begin
      wsat = WMax[WeightWidth-1:0];
    end else if (res < WMin) begin
      wsat = WMin[WeightWidth-1:0];
    end else begin
      wsat = res[WeightWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIssue;
      step_q  <= StepT;
      temp_q  <= TempReset;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      temp_q  <= cfg_wdata_i;
      state_q <= StIssue;
      step_q  <= StepT;
    end else begin
      case (state_q)
        StIdle: begin
          state_q <= StIdle;
        end
        StIssue: begin
          if (step_q == StepT || step_q == StepT3) begin
            step_q <= step_q + 5'd1;
          end else begin
            cnt_q   <= '0;
            state_q <= StIter;
          end
        end
        StIter: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (step_q == StepW2) begin
            state_q <= StIdle;
          end else begin
            step_q  <= step_q + 5'd1;
            state_q <= StIssue;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIssue: begin
        if (step_q == StepT) begin
          t_q  <= tc;
          t2_q <= {15'd0, tc} * {15'd0, tc};
        end else if (step_q == StepT3) begin
          t3_q <= {15'd0, t2_q} * {30'd0, t_q};
        end else begin
          ra_q <= abs_a;
          rb_q <= abs_b;
          rr_q <= '0;
        end
      end
      StIter: begin
        if (op_mul) begin
          if (rb_q[0]) begin
            rr_q <= rr_q + ra_q;
          end
          ra_q <= {ra_q[62:0], 1'b0};
          rb_q <= {1'b0, rb_q[63:1]};
        end else if (rem_sh >= rb_q) begin
          rr_q <= rem_sh - rb_q;
          ra_q <= {ra_q[62:0], 1'b1};
        end else begin
          rr_q <= rem_sh;
          ra_q <= {ra_q[62:0], 1'b0};
        end
      end
      StDone: begin
        if (step_q == StepW1) begin
          w1_q <= wsat;
        end else if (step_q == StepW2) begin
          w2_q <= wsat;
        end else begin
          acc_q <= acc_new;
          case (dst)
            DstX:    x_q  <= acc_new[39:0];
            DstY:    y_q  <= acc_new[39:0];
            DstM:    m_q  <= acc_new[39:0];
            DstN1:   n1_q <= acc_new[39:0];
            DstN2:   n2_q <= acc_new[39:0];
            default: begin
            end
          endcase
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign busy_o       = (state_q != StIdle);
  assign weights_o.w1 = w1_q;
  assign weights_o.w2 = w2_q;

endmodule

`default_nettype wire

FILE: src/dis_front.sv
// Front end: takes wavelength beats, clamps and splits them into table index and fraction.
`default_nettype none

module dis_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dis_pkg::WlWidth-1:0]   wavelength_nm_i,
  input  logic                          busy_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output dis_pkg::item_t                item_o
);
  import dis_pkg::*;

  localparam logic [WlWidth-1:0]  WlFirst = 10'd300;
  localparam logic [WlWidth-1:0]  WlLast  = 10'd830;
  localparam logic [IdxWidth-1:0] IdxLast = IdxWidth'(TabLen - 1);

  logic                 valid_q;
  item_t                item_q, item_d;
  logic [WlWidth-1:0]   diff, rem;
  logic [16:0]          prod;
  logic [IdxWidth-1:0]  quo;
  logic                 accept, advance;

  // divide by 5 through a reciprocal, exact for diff below 530
  always_comb begin
    diff = wavelength_nm_i - WlFirst;
    prod = {7'd0, diff} * 17'd205;
    quo  = prod[16:10];
    rem  = diff - ({3'd0, quo} * 10'd5);
    item_d.wl = wavelength_nm_i;
    if (wavelength_nm_i >= WlLast) begin
      item_d.idx  = IdxLast;
      item_d.frac = '0;
    end else if (wavelength_nm_i > WlFirst) begin
      item_d.idx  = quo;
      item_d.frac = rem[FracWidth-1:0];
    end else begin
      item_d.idx  = '0;
      item_d.frac = '0;
    end
  end

  assign advance    = !valid_q || !q_full_i;
  assign in_stall_o = busy_i || !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !q_full_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/dis_queue.sv
// Small FIFO between the front end and the evaluation pipeline.
`default_nettype none

module dis_queue #(
  parameter int Depth = dis_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dis_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output dis_pkg::item_t  item_o
);
  import dis_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/dis_back.sv
// Evaluation pipeline: table interpolation, weighted sum, rounding and saturation.
`default_nettype none

module dis_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  dis_pkg::item_t                      item_i,
  output logic                                pop_o,
  input  dis_pkg::weights_t                   weights_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dis_pkg::WlWidth-1:0]         wavelength_echo_o,
  output logic signed [dis_pkg::PowWidth-1:0] spectral_power_o
);
  import dis_pkg::*;

  localparam logic [IdxWidth-1:0] IdxLast = IdxWidth'(TabLen - 1);
  // output range in units of 256*1/32000 before the divide by 125
  localparam logic signed [35:0] ULo    = -36'sd524288000;
  localparam logic signed [35:0] UHi    = 36'sd524287875;
  localparam logic [29:0]         UTop   = 30'd1048575875;
  localparam logic [30:0]         Recip  = 31'd1099511628;  // ceil(2^37 / 125)
  localparam logic [23:0]         QBias  = 24'd4194304;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;
  logic [WlWidth-1:0] wl1_q, wl2_q, wl3_q, wl4_q, wl5_q, wl6_q;

  logic [IdxWidth-1:0]          idx_hi;
  logic signed [3:0]            fw, ff;
  logic signed [SampleWidth-1:0] a0_d, a1_d, a2_d, a0_q, a1_q, a2_q;
  logic signed [37:0]           p0_q;
  logic signed [41:0]           p1_q, p2_q;
  logic signed [43:0]           sum_q;
  logic signed [35:0]           u;
  logic [29:0]                  u_d, u_q;
  logic [60:0]                  prod_q;
  logic [23:0]                  q;
  logic signed [PowWidth-1:0]   pow_q;

  assign en6   = !v6_q || !out_stall_i;
  assign en5   = !v5_q || en6;
  assign en4   = !v4_q || en5;
  assign en3   = !v3_q || en4;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign pop_o = q_valid_i && en1;

  // linear interpolation, exact in units of 1/500
  always_comb begin
    idx_hi = (item_i.idx == IdxLast) ? item_i.idx : item_i.idx + 1'b1;
    ff     = $signed({1'b0, item_i.frac});
    fw     = 4'sd5 - ff;
    a0_d   = S0Tab[item_i.idx] * fw + S0Tab[idx_hi] * ff;
    a1_d   = S1Tab[item_i.idx] * fw + S1Tab[idx_hi] * ff;
    a2_d   = S2Tab[item_i.idx] * fw + S2Tab[idx_hi] * ff;
  end

  // floor(sum/256), clamped to the range that survives saturation, then biased positive
  always_comb begin
    u = sum_q[43:8];
    if (u < ULo) begin
      u_d = '0;
    end else if (u > UHi) begin
      u_d = UTop;
    end else begin
      u_d = 30'(u - ULo);
    end
  end

  assign q = prod_q[60:37] - QBias;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= q_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      wl1_q <= item_i.wl;
      a0_q  <= a0_d;
      a1_q  <= a1_d;
      a2_q  <= a2_d;
    end
    if (en2) begin
      wl2_q <= wl1_q;
      p0_q  <= $signed({a0_q, 20'd0});
      p1_q  <= weights_i.w1 * a1_q;
      p2_q  <= weights_i.w2 * a2_q;
    end
    if (en3) begin
      wl3_q <= wl2_q;
      sum_q <= p0_q + p1_q + p2_q + 44'sd16000;
    end
    if (en4) begin
      wl4_q <= wl3_q;
      u_q   <= u_d;
    end
    if (en5) begin
      wl5_q  <= wl4_q;
      prod_q <= {31'd0, u_q} * {30'd0, Recip};
    end
    if (en6) begin
      wl6_q <= wl5_q;
      pow_q <= q[PowWidth-1:0];
    end
  end

  assign out_valid_o       = v6_q;
  assign wavelength_echo_o = wl6_q;
  assign spectral_power_o  = pow_q;

endmodule

`default_nettype wire

FILE: src/daylight_illuminant_spectrum.sv
// Top level of the daylight illuminant spectral power evaluator.
//
// Input channel: wavelength_nm_i with in_valid_i / in_stall_o; one beat is one
// wavelength. Output channel: wavelength_echo_o and spectral_power_o (signed
// Q9.14) with out_valid_o / out_stall_i; one result beat per input beat, in order.
// Configuration: cfg_we_i writes the colour temperature from cfg_wdata_i.
// Throughput: one beat per cycle while in_stall_o is low; the front stage,
// a small queue and the six-stage evaluation pipeline each hold beats
// independently.
// Weight derivation: after reset and after every temperature write the serial
// mul/div engine recomputes the two weights: it forms t squared and t cubed, then
// runs 15 operations; in_stall_o stays high while the engine is busy.
// A stalled output holds its beat; the pipeline then fills, the queue fills and
// in_stall_o rises, with no beat lost.
`default_nettype none

`include "daylight_illuminant_spectrum_assert.svh"

module daylight_illuminant_spectrum #(
  parameter int QueueDepth = dis_pkg::QueueDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dis_pkg::TempWidth-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dis_pkg::WlWidth-1:0]         wavelength_nm_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dis_pkg::WlWidth-1:0]         wavelength_echo_o,
  output logic signed [dis_pkg::PowWidth-1:0] spectral_power_o
);
  import dis_pkg::*;

  logic     busy;
  weights_t weights;
  logic     push, q_full, q_valid, pop;
  item_t    front_item, q_item;

  dis_weights u_weights (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy),
    .weights_o   (weights)
  );

  dis_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .wavelength_nm_i (wavelength_nm_i),
    .busy_i          (busy),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (front_item)
  );

  dis_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  dis_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .item_i            (q_item),
    .pop_o             (pop),
    .weights_i         (weights),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .wavelength_echo_o (wavelength_echo_o),
    .spectral_power_o  (spectral_power_o)
  );

  `DIS_ASSERT_IMP(a_busy_blocks_input, clk_i, rst_ni, busy, in_stall_o, "input open while weights busy")
  `DIS_ASSERT_NXT(a_cfg_restarts, clk_i, rst_ni, cfg_we_i, busy, "config write did not restart engine")
  `DIS_ASSERT_NXT(a_weights_hold, clk_i, rst_ni, !busy && !cfg_we_i, $stable(weights), "weights changed while idle")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the daylight illuminant spectrum evaluator: self-checking, random handshakes.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dis_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainWait  = 40;

  typedef struct {
    logic [WlWidth-1:0]         wl;
    logic signed [PowWidth-1:0] pow;
  } sample_t;

  class spd_scoreboard;
    sample_t pending[$];
    int      errors;

    function void note(sample_t s);
      pending.push_back(s);
    endfunction

    function void check(logic [WlWidth-1:0] wl, logic signed [PowWidth-1:0] pow);
      sample_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat wl=%0d pow=%0d", $time, wl, pow);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (wl !== e.wl) begin
        $display("%0t: wavelength_echo expected %0d actual %0d", $time, e.wl, wl);
        errors++;
      end
      if (pow !== e.pow) begin
        $display("%0t: spectral_power (wl %0d) expected %0d actual %0d",
                 $time, e.wl, e.pow, pow);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [TempWidth-1:0]       cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [WlWidth-1:0]         wavelength_nm_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [WlWidth-1:0]         wavelength_echo_o;
  logic signed [PowWidth-1:0] spectral_power_o;

  daylight_illuminant_spectrum i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .wavelength_nm_i, .out_valid_o, .out_stall_i, .wavelength_echo_o, .spectral_power_o
  );

  always #5 clk_i = ~clk_i;

  spd_scoreboard sb = new();
  longint        w1_q, w2_q;
  bit            in_fire, calm;
  int unsigned   cycles;

  function automatic longint mul_q30(longint c, longint v);
    return (c * (v >>> 6)) >>> 24;
  endfunction

  function automatic longint weight(longint num, longint den);
    longint w;
    if (den == 0) return 0;
    w = (num * 64'sd1048576) / den;
    if (w > 8388607) w = 8388607;
    if (w < -8388608) w = -8388608;
    return w;
  endfunction

  function automatic void derive_weights(logic [TempWidth-1:0] temp);
    longint t, t2, t3, x, y, m, n1, n2;
    t = temp;
    if (t < 4000) t = 4000;
    if (t > 25000) t = 25000;
    t2 = t * t;
    t3 = t2 * t;
    if (t <= 7000)
      x = 64'sd262060651 + 64'sd106418552177 / t + 64'sd3186650985267200 / t2
        - 64'sd4946728583168000000 / t3;
    else
      x = 64'sd254519762 + 64'sd265729626604 / t + 64'sd2042042200883200 / t2
        - 64'sd2154355595673600000 / t3;
    y  = mul_q30(64'sd3081639035, x) - 3 * mul_q30(x, x) - 64'sd295279002;
    m  = 64'sd25877178 + mul_q30(64'sd275092655, x) - mul_q30(64'sd788233873, y);
    n1 = -64'sd1451162075 - mul_q30(64'sd1900845151, x) + mul_q30(64'sd6347317418, y);
    n2 = 64'sd32212255 - mul_q30(64'sd33761019927, x) + mul_q30(64'sd32289242009, y);
    w1_q = weight(n1, m);
    w2_q = weight(n2, m);
  endfunction

  function automatic sample_t predict_power(logic [WlWidth-1:0] wl);
    int     idx, frac;
    longint a0, a1, a2, sum, p;
    sample_t s;
    idx = 0;
    frac = 0;
    if (wl >= 830) idx = TabLen - 1;
    else if (wl > 300) begin
      idx  = (wl - 300) / 5;
      frac = (wl - 300) % 5;
    end
    a0 = 5 * longint'(S0Tab[idx]);
    a1 = 5 * longint'(S1Tab[idx]);
    a2 = 5 * longint'(S2Tab[idx]);
    if (frac != 0) begin
      a0 = longint'(S0Tab[idx]) * (5 - frac) + longint'(S0Tab[idx+1]) * frac;
      a1 = longint'(S1Tab[idx]) * (5 - frac) + longint'(S1Tab[idx+1]) * frac;
      a2 = longint'(S2Tab[idx]) * (5 - frac) + longint'(S2Tab[idx+1]) * frac;
    end
    sum = a0 * 64'sd1048576 + w1_q * a1 + w2_q * a2 + 16000;
    // floor division, rounds ties upward
    p = (sum >= 0) ? sum / 32000 : -((-sum + 31999) / 32000);
    if (p > 4194303) p = 4194303;
    if (p < -4194304) p = -4194304;
    s.wl  = wl;
    s.pow = p[PowWidth-1:0];
    return s;
  endfunction

  // beats are judged at the falling edge; inputs are stable until the next rising edge
  always @(negedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) sb.note(predict_power(wavelength_nm_i));
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(wavelength_echo_o, spectral_power_o);
  end

  // receiver stall bursts
  int stall_left = 0, run_left = 0;
  always @(posedge clk_i) begin
    if (calm) out_stall_i <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      stall_left <= $urandom_range(9, 1);
      run_left   <= $urandom_range(30, 1);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(logic [WlWidth-1:0] wl);
    int gap;
    gap = (!calm && $urandom_range(3, 0) == 0) ? $urandom_range(9, 1) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    wavelength_nm_i <= wl;
    do @(posedge clk_i); while (!in_fire);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_temp(logic [TempWidth-1:0] temp);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= temp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    derive_weights(temp);
  endtask

  task automatic random_batch(int n);
    repeat (n) begin
      if ($urandom_range(7, 0) == 0) send_beat(WlWidth'($urandom_range(1023, 0)));
      else send_beat(WlWidth'($urandom_range(830, 300)));
    end
  endtask

  logic [TempWidth-1:0] temps[8] = '{15'd4000, 15'd25000, 15'd7000, 15'd7001,
                                     15'd0, 15'd32767, 15'd16384, 15'd5000};
  int unsigned directed[] = '{0, 1023, 299, 300, 301, 302, 303, 304, 305, 560,
                              829, 830, 831, 512, 341, 682, 455};

  initial begin
    calm = 1'b0;
    derive_weights(TempReset);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_beat(WlWidth'(directed[i]));
    random_batch(40);
    drain();   // sender holds off until every result is back
    random_batch(20);

    foreach (temps[k]) begin
      write_temp(temps[k]);
      foreach (directed[i]) if (i < 6) send_beat(WlWidth'(directed[i]));
      random_batch(30);
    end
    write_temp(TempWidth'($urandom_range(25000, 4000)));
    random_batch(40);
    calm = 1'b1;
    random_batch(60);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+src
src/dis_pkg.sv
src/dis_weights.sv
src/dis_front.sv
src/dis_queue.sv
src/dis_back.sv
src/daylight_illuminant_spectrum.sv
sim/tb_top.sv
